[rtl/assert_macros.svh]
// Assertion helpers, clocked on clk with synchronous active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[rtl/pfi_pkg.sv]
package pfi_pkg;

  localparam int MaxDigits = 20;
  localparam int ArgWidth  = 64;
  localparam int IdxW      = $clog2(MaxDigits);
  localparam int CntW      = $clog2(ArgWidth + 1);

  typedef logic [MaxDigits-1:0][3:0] digits_t;

  typedef enum logic [1:0] {
    FUNC_CHAR = 2'd0,
    FUNC_ARG  = 2'd1,
    FUNC_END  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_FLAGS, PH_WIDTH, PH_PSTART, PH_PDIG, PH_LEN, PH_WSTAR, PH_WARG
  } phase_t;

  typedef enum logic [2:0] {
    CV_NONE, CV_C, CV_D, CV_U, CV_XL, CV_XU, CV_P
  } conv_t;

  typedef enum logic [2:0] {
    S_IDLE, S_PRE, S_CONV, S_SKIP, S_DIG
  } state_t;

  typedef struct packed {
    logic                start;
    logic                hex;
    logic [ArgWidth-1:0] value;
  } conv_req_t;

  function automatic logic [7:0] hex_char(logic [3:0] d, logic upper);
    logic [7:0] base;
    base = upper ? 8'h37 : 8'h57;
    return (d < 4'd10) ? (8'h30 + {4'h0, d}) : (base + {4'h0, d});
  endfunction

endpackage

[rtl/pfi_b2d.sv]
module pfi_b2d (
  input  logic              clk,
  input  logic              rst_n,
  input  pfi_pkg::conv_req_t req,
  output logic              busy,
  output pfi_pkg::digits_t  digits
);

  logic                            busy_r, busy_nxt;
  logic [pfi_pkg::CntW-1:0]        cnt_r, cnt_nxt;
  logic [pfi_pkg::ArgWidth-1:0]    sh_r, sh_nxt;
  pfi_pkg::digits_t                dig_r, dig_nxt;
  pfi_pkg::digits_t                adj;
  logic [pfi_pkg::MaxDigits*4-1:0] adj_flat;

  always_comb begin
    for (int i = 0; i < pfi_pkg::MaxDigits; i++) begin
      adj[i] = (dig_r[i] >= 4'd5) ? dig_r[i] + 4'd3 : dig_r[i];
    end
  end

  assign adj_flat = adj;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    dig_nxt  = dig_r;
    if (req.start) begin
      if (req.hex) begin
        busy_nxt = 1'b0;
        dig_nxt  = pfi_pkg::digits_t'({{(pfi_pkg::MaxDigits*4-pfi_pkg::ArgWidth){1'b0}},
                                       req.value});
      end else begin
        busy_nxt = 1'b1;
        cnt_nxt  = pfi_pkg::CntW'(pfi_pkg::ArgWidth);
        sh_nxt   = req.value;
        dig_nxt  = '0;
      end
    end else if (busy_r) begin
      // shift-add-3 step
      dig_nxt  = pfi_pkg::digits_t'({adj_flat[pfi_pkg::MaxDigits*4-2:0],
                                     sh_r[pfi_pkg::ArgWidth-1]});
      sh_nxt   = {sh_r[pfi_pkg::ArgWidth-2:0], 1'b0};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != pfi_pkg::CntW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    dig_r <= dig_nxt;
  end

  assign busy   = busy_r;
  assign digits = dig_r;

endmodule

[rtl/printf_integer_formatter.sv]
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | func, format_char, arg_value
// out_    | output    | out_valid/out_stall| kind, out_byte, written_total, last
// cfg_    | input     | cfg_valid/cfg_ready| long_is_64
// An item that emits nothing is taken in S_IDLE alone; each plain result is loaded from S_PRE.
// Number: prefix in S_PRE, 64 shift-add-3 steps (decimal), up to 19 zero-skip, then digits.
// Hex skips the shift-add-3 loop; only decimal numbers run the converter's 64-step loop.
// Reset is synchronous, active low; it clears parse state and count and sets long_is_64 to 1.
// in_stall is high from acceptance until the item's last result is loaded out;
// out_stall holds a valid output register and pauses loading in S_PRE and S_DIG.
`include "assert_macros.svh"
module printf_integer_formatter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_format_char,
  input  logic [63:0] in_arg_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_out_byte,
  output logic [31:0] out_written_total,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_long_is_64
);

  pfi_pkg::state_t state_r, state_nxt;
  pfi_pkg::phase_t phase_r, phase_nxt;
  pfi_pkg::conv_t  pend_r, pend_nxt;
  logic [1:0]  lcnt_r, lcnt_nxt;
  logic [31:0] count_r, count_nxt;
  logic        long64_r;
  pfi_pkg::kind_t pk0_r, pk0_nxt, pk1_r, pk1_nxt;
  logic [7:0]  pb0_r, pb0_nxt, pb1_r, pb1_nxt;
  logic        two_r, two_nxt, pidx_r, pidx_nxt;
  logic        num_r, num_nxt, hex_r, hex_nxt, upper_r, upper_nxt;
  logic [63:0] val_r, val_nxt;
  logic [pfi_pkg::IdxW-1:0] idx_r, idx_nxt;
  logic        ov_r, ov_nxt, ol_r, ol_nxt;
  pfi_pkg::kind_t ok_r, ok_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic [31:0] ot_r, ot_nxt;

  pfi_pkg::conv_req_t req;
  logic             busy;
  pfi_pkg::digits_t digits;

  pfi_b2d u_b2d (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .busy   (busy),
    .digits (digits)
  );

  always_comb begin
    logic        out_free, ld, ld_last, waiting, early, isdig, wide;
    logic        p_two, p_any, n_num, n_hex, n_up;
    logic [7:0]  c, ld_byte, p_b0, p_b1;
    logic [63:0] a, v, n_val;
    pfi_pkg::kind_t ld_kind, p_k0, p_k1;
    pfi_pkg::conv_t cv;
    logic [3:0]  d;

    state_nxt = state_r;  phase_nxt = phase_r;  pend_nxt = pend_r;
    lcnt_nxt = lcnt_r;    count_nxt = count_r;
    pk0_nxt = pk0_r; pk1_nxt = pk1_r; pb0_nxt = pb0_r; pb1_nxt = pb1_r;
    two_nxt = two_r; pidx_nxt = pidx_r; num_nxt = num_r; hex_nxt = hex_r;
    upper_nxt = upper_r; val_nxt = val_r; idx_nxt = idx_r;
    ov_nxt = ov_r; ok_nxt = ok_r; ob_nxt = ob_r; ot_nxt = ot_r; ol_nxt = ol_r;
    req = '0;
    out_free = !ov_r || !out_stall;
    ld = 1'b0; ld_last = 1'b0; ld_byte = 8'h00; ld_kind = pfi_pkg::KIND_BYTE;
    c = in_format_char; a = in_arg_value;
    waiting = (phase_r == pfi_pkg::PH_WSTAR) || (phase_r == pfi_pkg::PH_WARG);
    early = (phase_r == pfi_pkg::PH_FLAGS) || (phase_r == pfi_pkg::PH_WIDTH);
    isdig = (c >= "0") && (c <= "9");
    wide = (lcnt_r >= 2'd2) || ((lcnt_r == 2'd1) && long64_r);
    p_any = 1'b0; p_two = 1'b0; p_k0 = pfi_pkg::KIND_BYTE; p_k1 = pfi_pkg::KIND_BYTE;
    p_b0 = 8'h00; p_b1 = 8'h00; n_num = 1'b0; n_hex = 1'b0; n_up = 1'b0; n_val = a;
    v = a; cv = pfi_pkg::CV_NONE;
    d = digits[idx_r];

    unique case (state_r)
      pfi_pkg::S_IDLE: begin
        if (in_valid) begin
          if ((in_func == pfi_pkg::FUNC_CHAR) && !waiting) begin
            priority if (phase_r == pfi_pkg::PH_IDLE) begin
              if (c == "%") begin
                phase_nxt = pfi_pkg::PH_FLAGS; lcnt_nxt = '0; pend_nxt = pfi_pkg::CV_NONE;
              end else begin
                p_any = 1'b1; p_b0 = c;
              end
            end else if ((phase_r == pfi_pkg::PH_FLAGS) && (c == "-" || c == "+" ||
                         c == " " || c == "0" || c == "#")) begin
            end else if (early && isdig) begin
              phase_nxt = pfi_pkg::PH_WIDTH;
            end else if (early && c == ".") begin
              phase_nxt = pfi_pkg::PH_PSTART;
            end else if ((phase_r == pfi_pkg::PH_PSTART) && c == "*") begin
              phase_nxt = pfi_pkg::PH_WSTAR;
            end else if (((phase_r == pfi_pkg::PH_PSTART) ||
                          (phase_r == pfi_pkg::PH_PDIG)) && isdig) begin
              phase_nxt = pfi_pkg::PH_PDIG;
            end else if (c == "l" || c == "h" || c == "z" || c == "j" || c == "t") begin
              if (c == "l" && lcnt_r != 2'd3) lcnt_nxt = lcnt_r + 2'd1;
              phase_nxt = pfi_pkg::PH_LEN;
            end else begin
              priority if (c == "c") cv = pfi_pkg::CV_C;
              else if (c == "d" || c == "i") cv = pfi_pkg::CV_D;
              else if (c == "u") cv = pfi_pkg::CV_U;
              else if (c == "x") cv = pfi_pkg::CV_XL;
              else if (c == "X") cv = pfi_pkg::CV_XU;
              else if (c == "p") cv = pfi_pkg::CV_P;
              else cv = pfi_pkg::CV_NONE;
              if (cv != pfi_pkg::CV_NONE) begin
                pend_nxt = cv; phase_nxt = pfi_pkg::PH_WARG;
              end else begin
                p_any = 1'b1; p_b0 = "%"; p_two = (c != "%"); p_b1 = c;
                phase_nxt = pfi_pkg::PH_IDLE; lcnt_nxt = '0; pend_nxt = pfi_pkg::CV_NONE;
              end
            end
          end else if ((in_func == pfi_pkg::FUNC_ARG) && (phase_r == pfi_pkg::PH_WSTAR)) begin
            phase_nxt = pfi_pkg::PH_LEN;
          end else if ((in_func == pfi_pkg::FUNC_ARG) && (phase_r == pfi_pkg::PH_WARG)) begin
            unique case (pend_r)
              pfi_pkg::CV_C: begin
                p_any = 1'b1; p_b0 = a[7:0];
              end
              pfi_pkg::CV_D: begin
                v = wide ? a : {{32{a[31]}}, a[31:0]};
                if (v[63]) begin
                  p_any = 1'b1; p_b0 = "-"; v = 64'd0 - v;
                end
                n_num = 1'b1; n_val = v;
              end
              pfi_pkg::CV_U, pfi_pkg::CV_XL, pfi_pkg::CV_XU: begin
                n_num = 1'b1; n_val = wide ? a : {32'h0, a[31:0]};
                n_hex = (pend_r != pfi_pkg::CV_U); n_up = (pend_r == pfi_pkg::CV_XU);
              end
              pfi_pkg::CV_P: begin
                p_any = 1'b1; p_two = 1'b1; p_b0 = "0"; p_b1 = "x";
                n_num = 1'b1; n_hex = 1'b1; n_val = long64_r ? a : {32'h0, a[31:0]};
              end
              default: begin
              end
            endcase
            phase_nxt = pfi_pkg::PH_IDLE; lcnt_nxt = '0; pend_nxt = pfi_pkg::CV_NONE;
          end else if ((in_func == pfi_pkg::FUNC_END) && !waiting) begin
            p_any = 1'b1;
            if (phase_r != pfi_pkg::PH_IDLE) begin
              p_b0 = "%"; p_two = 1'b1; p_k1 = pfi_pkg::KIND_COUNT;
            end else begin
              p_k0 = pfi_pkg::KIND_COUNT;
            end
            phase_nxt = pfi_pkg::PH_IDLE; lcnt_nxt = '0; pend_nxt = pfi_pkg::CV_NONE;
          end else begin
            p_any = 1'b1; p_k0 = pfi_pkg::KIND_ERROR;
          end
          pk0_nxt = p_k0; pk1_nxt = p_k1; pb0_nxt = p_b0; pb1_nxt = p_b1;
          two_nxt = p_two; pidx_nxt = 1'b0; num_nxt = n_num; hex_nxt = n_hex;
          upper_nxt = n_up; val_nxt = n_val;
          if (p_any) begin
            state_nxt = pfi_pkg::S_PRE;
          end else if (n_num) begin
            req.start = 1'b1; req.hex = n_hex; req.value = n_val;
            state_nxt = pfi_pkg::S_CONV;
          end
        end
      end
      pfi_pkg::S_PRE: begin
        if (out_free) begin
          ld = 1'b1;
          ld_kind = pidx_r ? pk1_r : pk0_r;
          ld_byte = pidx_r ? pb1_r : pb0_r;
          ld_last = (pidx_r == two_r) && !num_r;
          if (pidx_r == two_r) begin
            if (num_r) begin
              req.start = 1'b1; req.hex = hex_r; req.value = val_r;
              state_nxt = pfi_pkg::S_CONV;
            end else begin
              state_nxt = pfi_pkg::S_IDLE;
            end
          end else begin
            pidx_nxt = 1'b1;
          end
        end
      end
      pfi_pkg::S_CONV: begin
        if (!busy) begin
          idx_nxt = pfi_pkg::IdxW'(pfi_pkg::MaxDigits - 1);
          state_nxt = pfi_pkg::S_SKIP;
        end
      end
      pfi_pkg::S_SKIP: begin
        if ((idx_r != '0) && (d == 4'd0)) idx_nxt = idx_r - 1'b1;
        else state_nxt = pfi_pkg::S_DIG;
      end
      pfi_pkg::S_DIG: begin
        if (out_free) begin
          ld = 1'b1; ld_byte = pfi_pkg::hex_char(d, upper_r); ld_last = (idx_r == '0);
          if (idx_r == '0) state_nxt = pfi_pkg::S_IDLE;
          else idx_nxt = idx_r - 1'b1;
        end
      end
      default: state_nxt = pfi_pkg::S_IDLE;
    endcase

    if (ld) begin
      ov_nxt = 1'b1; ok_nxt = ld_kind; ol_nxt = ld_last; ob_nxt = 8'h00; ot_nxt = '0;
      if (ld_kind == pfi_pkg::KIND_BYTE) begin
        ob_nxt = ld_byte;
        if (count_r != 32'hFFFF_FFFF) count_nxt = count_r + 32'd1;
      end else if (ld_kind == pfi_pkg::KIND_COUNT) begin
        ot_nxt = count_r; count_nxt = '0;
      end
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pfi_pkg::S_IDLE;
      phase_r  <= pfi_pkg::PH_IDLE;
      pend_r   <= pfi_pkg::CV_NONE;
      lcnt_r   <= '0;
      count_r  <= '0;
      long64_r <= 1'b1;
      ov_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      lcnt_r  <= lcnt_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid) long64_r <= cfg_long_is_64;
    end
    pk0_r <= pk0_nxt; pk1_r <= pk1_nxt; pb0_r <= pb0_nxt; pb1_r <= pb1_nxt;
    two_r <= two_nxt; pidx_r <= pidx_nxt; num_r <= num_nxt; hex_r <= hex_nxt;
    upper_r <= upper_nxt; val_r <= val_nxt; idx_r <= idx_nxt;
    ok_r <= ok_nxt; ob_r <= ob_nxt; ot_r <= ot_nxt; ol_r <= ol_nxt;
  end

  assign in_stall          = (state_r != pfi_pkg::S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = ov_r;
  assign out_kind          = ok_r;
  assign out_out_byte      = ob_r;
  assign out_written_total = ot_r;
  assign out_last          = ol_r;

  `ASSERT_IMPL(a_dig_idle_unit, state_r == pfi_pkg::S_DIG || state_r == pfi_pkg::S_SKIP, !busy, "digit read while converter busy")
  `ASSERT_NEXT(a_skip_next, state_r == pfi_pkg::S_SKIP, state_r == pfi_pkg::S_SKIP || state_r == pfi_pkg::S_DIG, "skip left to wrong state")
  `ASSERT_NEXT(a_count_clear, ov_nxt && !(ov_r && out_stall) && ok_nxt == pfi_pkg::KIND_COUNT, count_r == 32'd0, "count not cleared after report")
  `ASSERT_IMPL(a_idle_phase_wait, state_r == pfi_pkg::S_CONV, phase_r == pfi_pkg::PH_IDLE, "conversion with parse still open")

endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  func;
    logic [7:0]  ch;
    logic [63:0] arg;
  } item_t;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  byte_v;
    logic [31:0] total;
    logic        last;
  } res_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_func = 0;
  logic [7:0]  in_format_char = 0;
  logic [63:0] in_arg_value = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  out_kind;
  logic [7:0]  out_out_byte;
  logic [31:0] out_written_total;
  logic        out_last;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_long_is_64 = 0;

  printf_integer_formatter dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // predictor state
  pfi_pkg::phase_t fmt_phase;
  pfi_pkg::conv_t  fmt_conv;
  logic [1:0]  l_count;
  logic [31:0] byte_total;
  logic        long64;

  item_t pending_items[$];
  res_t  expected_out[$];
  res_t  item_results[$];
  int    errors = 0;
  int    n_checked = 0;
  int    n_items = 0;
  int    cycles = 0;
  int    hold_cycles = 0;
  int    in_gap = 0;
  int    out_gap = 0;
  bit    stall_en = 1;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, n_checked);
  endtask

  function automatic void put_res(input logic [1:0] k, input logic [7:0] b,
                                  input logic [31:0] t);
    res_t r;
    r.kind = k; r.byte_v = b; r.total = t; r.last = 0;
    item_results.push_back(r);
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    put_res(pfi_pkg::KIND_BYTE, b, 0);
    if (byte_total != 32'hFFFF_FFFF) byte_total++;
  endfunction

  function automatic void put_number(input logic [63:0] v, input int radix, input bit upper);
    logic [3:0] d[$];
    logic [3:0] x;
    d = {};
    do begin
      d.push_front(v % radix);
      v = v / radix;
    end while (v != 0);
    foreach (d[i]) begin
      x = d[i];
      if (x < 10) put_byte(8'h30 + x);
      else put_byte((upper ? 8'h37 : 8'h57) + x);
    end
  endfunction

  function automatic void conv_done();
    fmt_phase = pfi_pkg::PH_IDLE; l_count = 0; fmt_conv = pfi_pkg::CV_NONE;
  endfunction

  function automatic void format_char(input logic [7:0] c);
    bit dig, early;
    pfi_pkg::conv_t cv;
    dig = c >= "0" && c <= "9";
    early = fmt_phase == pfi_pkg::PH_FLAGS || fmt_phase == pfi_pkg::PH_WIDTH;
    if (fmt_phase == pfi_pkg::PH_IDLE) begin
      if (c == "%") begin
        fmt_phase = pfi_pkg::PH_FLAGS; l_count = 0; fmt_conv = pfi_pkg::CV_NONE;
      end else put_byte(c);
      return;
    end
    if (fmt_phase == pfi_pkg::PH_FLAGS &&
        (c == "-" || c == "+" || c == " " || c == "0" || c == "#"))
      return;
    if (early && dig) begin fmt_phase = pfi_pkg::PH_WIDTH; return; end
    if (early && c == ".") begin fmt_phase = pfi_pkg::PH_PSTART; return; end
    if (fmt_phase == pfi_pkg::PH_PSTART && c == "*") begin
      fmt_phase = pfi_pkg::PH_WSTAR; return;
    end
    if ((fmt_phase == pfi_pkg::PH_PSTART || fmt_phase == pfi_pkg::PH_PDIG) && dig) begin
      fmt_phase = pfi_pkg::PH_PDIG; return;
    end
    if (c == "l" || c == "h" || c == "z" || c == "j" || c == "t") begin
      if (c == "l" && l_count < 3) l_count++;
      fmt_phase = pfi_pkg::PH_LEN;
      return;
    end
    case (c)
      "c": cv = pfi_pkg::CV_C;
      "d", "i": cv = pfi_pkg::CV_D;
      "u": cv = pfi_pkg::CV_U;
      "x": cv = pfi_pkg::CV_XL;
      "X": cv = pfi_pkg::CV_XU;
      "p": cv = pfi_pkg::CV_P;
      default: cv = pfi_pkg::CV_NONE;
    endcase
    if (cv != pfi_pkg::CV_NONE) begin
      fmt_conv = cv; fmt_phase = pfi_pkg::PH_WARG; return;
    end
    put_byte("%");
    if (c != "%") put_byte(c);
    conv_done();
  endfunction

  function automatic void format_arg(input logic [63:0] a);
    bit wide;
    logic [63:0] v;
    wide = l_count >= 2 || (l_count == 1 && long64);
    v = a;
    case (fmt_conv)
      pfi_pkg::CV_C: put_byte(a[7:0]);
      pfi_pkg::CV_D: begin
        if (!wide) v = {{32{a[31]}}, a[31:0]};
        if (v[63]) begin put_byte("-"); v = -v; end
        put_number(v, 10, 0);
      end
      pfi_pkg::CV_U, pfi_pkg::CV_XL, pfi_pkg::CV_XU: begin
        if (!wide) v = {32'h0, v[31:0]};
        put_number(v, fmt_conv == pfi_pkg::CV_U ? 10 : 16, fmt_conv == pfi_pkg::CV_XU);
      end
      pfi_pkg::CV_P: begin
        if (!long64) v = {32'h0, v[31:0]};
        put_byte("0"); put_byte("x");
        put_number(v, 16, 0);
      end
      default: ;
    endcase
    conv_done();
  endfunction

  function automatic void predict(input item_t it);
    bit waiting;
    waiting = fmt_phase == pfi_pkg::PH_WSTAR || fmt_phase == pfi_pkg::PH_WARG;
    item_results = {};
    if (it.func == pfi_pkg::FUNC_CHAR && !waiting) format_char(it.ch);
    else if (it.func == pfi_pkg::FUNC_ARG && fmt_phase == pfi_pkg::PH_WSTAR)
      fmt_phase = pfi_pkg::PH_LEN;
    else if (it.func == pfi_pkg::FUNC_ARG && fmt_phase == pfi_pkg::PH_WARG)
      format_arg(it.arg);
    else if (it.func == pfi_pkg::FUNC_END && !waiting) begin
      if (fmt_phase != pfi_pkg::PH_IDLE) put_byte("%");
      put_res(pfi_pkg::KIND_COUNT, 0, byte_total);
      byte_total = 0;
      conv_done();
    end else put_res(pfi_pkg::KIND_ERROR, 0, 0);
    if (item_results.size() > 0) item_results[$].last = 1;
    foreach (item_results[i]) expected_out.push_back(item_results[i]);
  endfunction

  // driver
  always @(posedge clk) begin
    item_t it;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict('{in_func, in_format_char, in_arg_value});
        n_items++;
      end
      if (!in_valid || !in_stall) begin
        if (in_valid && !in_stall) in_gap = $urandom_range(0, 4);
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          in_valid <= 1;
          in_func <= it.func;
          in_format_char <= it.ch;
          in_arg_value <= it.arg;
        end else in_valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t e;
    cycles++;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_checked++;
        if (expected_out.size() == 0) begin
          report("unexpected kind", out_kind, 0);
        end else begin
          e = expected_out.pop_front();
          if (out_kind !== e.kind) report("kind", out_kind, e.kind);
          if (out_out_byte !== e.byte_v) report("byte", out_out_byte, e.byte_v);
          if (out_written_total !== e.total) report("total", out_written_total, e.total);
          if (out_last !== e.last) report("last", out_last, e.last);
        end
        out_gap = $urandom_range(0, 4);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1;
      end else if (stall_en && out_gap > 0) begin
        out_gap--;
        out_stall <= 1;
      end else out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    if (cycles > 1500000) begin
      $display("[printf_integer_formatter] ERROR");
      $finish;
    end
  end

  function automatic void add_item(input logic [1:0] f, input logic [7:0] c,
                                   input logic [63:0] a);
    item_t it;
    it.func = f; it.ch = c; it.arg = a;
    pending_items.push_back(it);
  endfunction

  function automatic void add_str(input string s);
    foreach (s[i]) add_item(pfi_pkg::FUNC_CHAR, s[i], 0);
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = 64'hFFFF_FFFF_FFFF_FFFF;
      2: v = 64'h8000_0000_0000_0000;
      3: v = {$urandom, 32'h8000_0000};
      4: v = $urandom_range(0, 1000);
      default: ;
    endcase
    return v;
  endfunction

  function automatic void add_spec();
    string conv_letters = "diuxXpc";
    string flags = "-+ 0#";
    string lens = "lhzjt";
    add_item(pfi_pkg::FUNC_CHAR, "%", 0);
    repeat ($urandom_range(0, 2))
      add_item(pfi_pkg::FUNC_CHAR, flags[$urandom_range(0, 4)], 0);
    if ($urandom_range(0, 1)) add_item(pfi_pkg::FUNC_CHAR, "0" + $urandom_range(1, 9), 0);
    case ($urandom_range(0, 3))
      0: add_str(".3");
      1: begin add_str(".*"); add_item(pfi_pkg::FUNC_ARG, 0, rand64()); end
      default: ;
    endcase
    repeat ($urandom_range(0, 3)) add_item(pfi_pkg::FUNC_CHAR,
      $urandom_range(0, 2) ? "l" : lens[$urandom_range(0, 4)], 0);
    if ($urandom_range(0, 9) == 0) begin
      add_item(pfi_pkg::FUNC_CHAR, $urandom_range(0, 255), 0);
    end else begin
      add_item(pfi_pkg::FUNC_CHAR, conv_letters[$urandom_range(0, 6)], 0);
      add_item(pfi_pkg::FUNC_ARG, 0, rand64());
    end
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_out.size() > 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_cfg(input logic v);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_long_is_64 <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    long64 = v;
  endtask

  initial begin
    fmt_phase = pfi_pkg::PH_IDLE; fmt_conv = pfi_pkg::CV_NONE;
    l_count = 0; byte_total = 0; long64 = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // directed
    add_str("A%d"); add_item(pfi_pkg::FUNC_ARG, 0, 64'h0000_0000_8000_0000);
    add_str("%lld"); add_item(pfi_pkg::FUNC_ARG, 0, 64'h8000_0000_0000_0000);
    add_str("%lu"); add_item(pfi_pkg::FUNC_ARG, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    add_str("%X%"); add_item(pfi_pkg::FUNC_ARG, 0, 64'hFF);
    add_item(pfi_pkg::FUNC_ARG, 0, 1);
    add_str("%.*x"); add_item(pfi_pkg::FUNC_ARG, 0, 5);
    add_item(pfi_pkg::FUNC_ARG, 0, 64'hABC);
    add_str("%p"); add_item(pfi_pkg::FUNC_ARG, 0, 64'hDEAD_BEEF_0123_4567);
    add_str("%c%%%s%3.2*"); add_item(pfi_pkg::FUNC_ARG, 0, 64'h41);
    add_item(pfi_pkg::FUNC_CHAR, 0, 0); add_item(3, 8'hFF, 0);
    add_item(pfi_pkg::FUNC_END, 0, 0);
    add_str("%5"); add_item(pfi_pkg::FUNC_END, 0, 0);
    wait_drained();

    write_cfg(0);
    add_str("%ld%p%lld"); add_item(pfi_pkg::FUNC_ARG, 0, 64'hFFFF_FFFF_0000_0001);
    add_item(pfi_pkg::FUNC_ARG, 0, 64'h1234_5678_9ABC_DEF0);
    add_item(pfi_pkg::FUNC_ARG, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    add_item(pfi_pkg::FUNC_END, 0, 0);
    // long output stall while the sender keeps going
    hold_cycles = 400;
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(ph[0]);
      stall_en = ph != 2;
      while (pending_items.size() < 36) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: add_spec();
          5, 6: add_item(pfi_pkg::FUNC_CHAR, $urandom_range(0, 255), 0);
          7: add_item(pfi_pkg::FUNC_END, 0, 0);
          8: add_item(pfi_pkg::FUNC_ARG, 0, rand64());
          default: add_item($urandom_range(0, 3), $urandom_range(0, 255), rand64());
        endcase
      end
      add_item(pfi_pkg::FUNC_END, 0, 0);
      wait_drained();
    end
    write_cfg(1);

    $display("sent %0d items, checked %0d results over both long widths", n_items, n_checked);
    if (errors == 0) $display("[printf_integer_formatter] OK");
    else $display("[printf_integer_formatter] ERROR");
    $finish;
  end
endmodule
